// ----- rtl/keypad_matrix_scan_controller_top_macros.svh -----
// Assertion macros shared by the keypad scan controller RTL.
`ifndef KEYPAD_MATRIX_SCAN_CONTROLLER_TOP_MACROS_SVH
`define KEYPAD_MATRIX_SCAN_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KMSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kmsc_pkg.sv -----
// Types, register codes, masks and helper functions of the keypad scan controller.
`timescale 1ns / 1ps

package kmsc_pkg;

  typedef enum logic [2:0] {
    OP_BUS_READ   = 3'd0,
    OP_BUS_WRITE  = 3'd1,
    OP_MATRIX_KEY = 3'd2,
    OP_DIRECT_KEY = 3'd3,
    OP_JOG_STEP   = 3'd4
  } op_t;

  // Register index: byte offset divided by eight
  localparam logic [3:0] REG_CONTROL  = 4'd0;
  localparam logic [3:0] REG_DIRECT   = 4'd1;
  localparam logic [3:0] REG_JOG      = 4'd2;
  localparam logic [3:0] REG_MANUAL   = 4'd3;
  localparam logic [3:0] REG_SCAN     = 4'd4;
  localparam logic [3:0] REG_MULTI0   = 4'd5;
  localparam logic [3:0] REG_MULTI1   = 4'd6;
  localparam logic [3:0] REG_MULTI2   = 4'd7;
  localparam logic [3:0] REG_MULTI3   = 4'd8;
  localparam logic [3:0] REG_DEBOUNCE = 4'd9;

  localparam logic [6:0] LAST_OFFSET = 7'h48;
  localparam logic [2:0] BUS_BYTES   = 3'd4;

  localparam logic [31:0] CTRL_KEEP_MASK  = 32'h0040_0020;
  localparam logic [31:0] CTRL_WRITE_MASK = 32'h7fbf_fbdf;
  localparam logic [31:0] CTRL_MATRIX_INT = 32'h0040_0000;
  localparam logic [31:0] CTRL_DIRECT_INT = 32'h0000_0020;
  localparam logic [31:0] IRQ_MATRIX_MASK = 32'h0040_1800;
  localparam logic [31:0] IRQ_DIRECT_MASK = 32'h0000_0023;
  localparam logic [31:0] SCAN_CLEAR_MASK = 32'h7c00_00ff;
  localparam logic [31:0] SCAN_SINGLE     = 32'h0400_0000;
  localparam logic [31:0] SCAN_MULTI      = 32'h1000_00ff;
  localparam logic [31:0] SCAN_RESET      = 32'h0000_00ff;
  localparam logic [31:0] STATUS_CHANGED  = 32'h8000_0000;
  localparam logic [15:0] JOG_MASK        = 16'hc0ff;
  localparam logic [15:0] JOG_KEEP_MASK   = 16'h0300;
  localparam logic [15:0] JOG_FLAG_MASK   = 16'hc000;
  localparam logic [15:0] DEBOUNCE_RESET  = 16'h0064;

  function automatic logic irq_level(input logic [31:0] ctrl);
    return ((ctrl & IRQ_MATRIX_MASK) == IRQ_MATRIX_MASK) ||
           ((ctrl & IRQ_DIRECT_MASK) == IRQ_DIRECT_MASK);
  endfunction

  function automatic logic [1:0] phase_up(input logic [1:0] ph);
    logic [1:0] r;
    unique case (ph)
      2'd0: r = 2'd2;
      2'd1: r = 2'd0;
      2'd2: r = 2'd3;
      2'd3: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] phase_down(input logic [1:0] ph);
    logic [1:0] r;
    unique case (ph)
      2'd0: r = 2'd1;
      2'd1: r = 2'd3;
      2'd2: r = 2'd2;
      2'd3: r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // One dial step: 8-bit count, overflow/underflow flags, rotating sensor phase
  function automatic logic [15:0] jog_next(input logic [15:0] s, input logic up);
    logic [15:0] t;
    logic [1:0]  ph;
    if (up) begin
      if (s[7:0] == 8'hff) t = (s & 16'h4300) | 16'h8000;
      else t = s + 16'd1;
      ph = phase_up(t[13:12]);
    end else begin
      if (s[7:0] == 8'h00) t = (s & 16'h8300) | 16'h40ff;
      else t = s - 16'd1;
      ph = phase_down(t[13:12]);
    end
    return (t & JOG_MASK) | {2'b00, ph, 12'h000};
  endfunction

endpackage

// ----- rtl/keypad_matrix_scan_controller_top.sv -----
// Keypad controller top level: register file, key maps, scan logic and jog dials.
//
// One item (bus read, bus write, matrix key, direct key or jog step) enters per
// clock unless the result side stalls, and gives one result item (read data,
// access-ok flag, interrupt level). An input register holds the item, the
// register update and column scan are worked out in a single combinational pass
// over the eight matrix columns, and a result register holds the answer. The
// input side keeps accepting while a result waits, until both registers are full.
`timescale 1ns / 1ps
`include "keypad_matrix_scan_controller_top_macros.svh"

module keypad_matrix_scan_controller_top #(
  parameter int unsigned MATRIX_COLS = 8,
  parameter int unsigned MATRIX_ROWS = 8,
  parameter int unsigned JOG_DIALS   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [6:0]  in_reg_offset,
  input  logic [2:0]  in_access_bytes,
  input  logic [31:0] in_write_data,
  input  logic [2:0]  in_matrix_row,
  input  logic [2:0]  in_matrix_col,
  input  logic [2:0]  in_direct_index,
  input  logic        in_jog_index,
  input  logic        in_pressed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_access_ok,
  output logic        out_irq
);

  // Input register
  logic        s1_valid_r, s1_valid_nxt;
  logic [2:0]  s1_opcode_r;
  logic [6:0]  s1_offset_r;
  logic [2:0]  s1_bytes_r;
  logic [31:0] s1_wdata_r;
  logic [2:0]  s1_row_r;
  logic [2:0]  s1_col_r;
  logic [2:0]  s1_didx_r;
  logic        s1_jidx_r;
  logic        s1_pressed_r;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_read_data_r;
  logic        out_access_ok_r;
  logic        out_irq_r;

  // Block state
  logic [31:0]            control_r, control_mid, control_nxt;
  logic [31:0]            manual_status_r, manual_mid, manual_status_nxt;
  logic [31:0]            scan_status_r, scan_status_nxt;
  logic [31:0]            multi_scan_r [4];
  logic [31:0]            multi_scan_nxt [4];
  logic [15:0]            debounce_r, debounce_nxt;
  logic                   direct_changed_r, direct_changed_nxt;
  logic [63:0]            previous_scan_r, previous_scan_nxt;
  logic [MATRIX_ROWS-1:0] matrix_map_r [MATRIX_COLS];
  logic [7:0]             direct_map_r, direct_map_nxt;
  logic [6:0]             pressed_count_r, pressed_count_nxt;
  logic [15:0]            jog_state_r [2];
  logic [15:0]            jog_state_nxt [2];

  logic        in_fire, adv;
  logic [7:0]  col_val [8];
  logic [7:0]  col_eff [8];
  logic [7:0]  key_bit;
  logic        key_in_range, key_chg;
  logic        bus_ok;
  logic [3:0]  reg_idx;
  logic [31:0] rd_v;
  logic        ok_v;
  logic        run_scan, run_recalc, went_down;

  // Scan products
  logic [7:0]  row_mask;
  logic [2:0]  last_col;
  logic [7:0]  scan_v [8];
  logic [63:0] scan_now;
  logic [31:0] scan_words [4];
  logic [7:0]  col_nz;
  logic        col_multi;
  logic [7:0]  single_v;
  logic [2:0]  pos_col, pos_row;
  logic        single_key;
  logic [31:0] scan_set;
  logic [7:0]  manual_v;
  logic        do_auto, do_manual;

  // ---------------------------------------------------------------- handshake
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // ---------------------------------------------------------------- key map view
  for (genvar g = 0; g < 8; g++) begin : g_col
    if (g < MATRIX_COLS) begin : g_used
      assign col_val[g] = 8'(matrix_map_r[g]);
    end else begin : g_unused
      assign col_val[g] = 8'h00;
    end
  end

  assign key_bit      = 8'h01 << s1_row_r;
  assign key_in_range = ({1'b0, s1_row_r} < 4'(MATRIX_ROWS)) &&
                        ({1'b0, s1_col_r} < 4'(MATRIX_COLS));
  assign key_chg      = (s1_opcode_r == kmsc_pkg::OP_MATRIX_KEY) && key_in_range &&
                        (col_val[s1_col_r][s1_row_r] != s1_pressed_r);

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      col_eff[c] = col_val[c] ^ ((key_chg && (s1_col_r == 3'(c))) ? key_bit : 8'h00);
    end
  end

  // ---------------------------------------------------------------- item decode
  assign reg_idx = s1_offset_r[6:3];
  assign bus_ok  = (s1_bytes_r == kmsc_pkg::BUS_BYTES) && (s1_offset_r[2:0] == 3'd0) &&
                   (s1_offset_r <= kmsc_pkg::LAST_OFFSET);

  always_comb begin
    control_mid        = control_r;
    manual_mid         = manual_status_r;
    debounce_nxt       = debounce_r;
    direct_changed_nxt = direct_changed_r;
    direct_map_nxt     = direct_map_r;
    pressed_count_nxt  = pressed_count_r;
    jog_state_nxt[0]   = jog_state_r[0];
    jog_state_nxt[1]   = jog_state_r[1];
    rd_v               = 32'd0;
    ok_v               = 1'b0;
    run_scan           = 1'b0;
    run_recalc         = 1'b0;
    went_down          = 1'b0;

    unique case (s1_opcode_r)
      kmsc_pkg::OP_BUS_READ: begin
        if (bus_ok) begin
          ok_v = 1'b1;
          unique case (reg_idx)
            kmsc_pkg::REG_CONTROL: begin
              rd_v        = control_r;
              control_mid = control_r & ~kmsc_pkg::CTRL_KEEP_MASK;
            end
            kmsc_pkg::REG_DIRECT: begin
              rd_v = {direct_changed_r, 23'd0, ~direct_map_r};
              // substitute the sensor phase of dial 0 where enabled
              if (control_r[2]) rd_v[1:0] = jog_state_r[0][13:12];
              if (control_r[3]) rd_v[3:2] = jog_state_r[0][13:12];
              direct_changed_nxt = 1'b0;
            end
            kmsc_pkg::REG_JOG: begin
              rd_v = {jog_state_r[1] & kmsc_pkg::JOG_MASK, jog_state_r[0] & kmsc_pkg::JOG_MASK};
              jog_state_nxt[0] = jog_state_r[0] & ~kmsc_pkg::JOG_FLAG_MASK;
              jog_state_nxt[1] = jog_state_r[1] & ~kmsc_pkg::JOG_FLAG_MASK;
            end
            kmsc_pkg::REG_MANUAL: begin
              rd_v       = manual_status_r;
              manual_mid = manual_status_r & ~kmsc_pkg::STATUS_CHANGED;
            end
            kmsc_pkg::REG_SCAN:     rd_v = scan_status_r;
            kmsc_pkg::REG_MULTI0,
            kmsc_pkg::REG_MULTI1,
            kmsc_pkg::REG_MULTI2,
            kmsc_pkg::REG_MULTI3:   rd_v = multi_scan_r[2'(reg_idx - kmsc_pkg::REG_MULTI0)];
            kmsc_pkg::REG_DEBOUNCE: rd_v = {16'd0, debounce_r};
            default:                rd_v = 32'd0;
          endcase
        end
      end
      kmsc_pkg::OP_BUS_WRITE: begin
        if (bus_ok) begin
          ok_v = 1'b1;
          unique case (reg_idx)
            kmsc_pkg::REG_CONTROL: begin
              control_mid = (control_r & kmsc_pkg::CTRL_KEEP_MASK) |
                            (s1_wdata_r & kmsc_pkg::CTRL_WRITE_MASK);
              // bit 31 forces an automatic scan that raises no interrupt
              if (s1_wdata_r[31]) run_scan = 1'b1;
              else run_recalc = 1'b1;
            end
            kmsc_pkg::REG_JOG: begin
              jog_state_nxt[0] = (jog_state_r[0] & kmsc_pkg::JOG_KEEP_MASK) |
                                 (s1_wdata_r[15:0] & kmsc_pkg::JOG_MASK);
              jog_state_nxt[1] = (jog_state_r[1] & kmsc_pkg::JOG_KEEP_MASK) |
                                 (s1_wdata_r[31:16] & kmsc_pkg::JOG_MASK);
            end
            kmsc_pkg::REG_DEBOUNCE: debounce_nxt = s1_wdata_r[15:0];
            default: ;  // read-only registers drop the write
          endcase
        end
      end
      kmsc_pkg::OP_MATRIX_KEY: begin
        if (key_chg) begin
          pressed_count_nxt = s1_pressed_r ? pressed_count_r + 7'd1 : pressed_count_r - 7'd1;
          manual_mid        = manual_status_r | kmsc_pkg::STATUS_CHANGED;
          run_recalc        = 1'b1;
          went_down         = s1_pressed_r;
        end
      end
      kmsc_pkg::OP_DIRECT_KEY: begin
        if (direct_map_r[s1_didx_r] != s1_pressed_r) begin
          direct_map_nxt                = direct_map_r;
          direct_map_nxt[s1_didx_r]     = s1_pressed_r;
          direct_changed_nxt            = 1'b1;
          control_mid                   = control_r | kmsc_pkg::CTRL_DIRECT_INT;
        end
      end
      kmsc_pkg::OP_JOG_STEP: begin
        if ({1'b0, s1_jidx_r} < 2'(JOG_DIALS)) begin
          jog_state_nxt[s1_jidx_r] = kmsc_pkg::jog_next(jog_state_r[s1_jidx_r], s1_pressed_r);
          control_mid              = control_r | kmsc_pkg::CTRL_DIRECT_INT;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- column scan
  assign last_col = control_mid[25:23];

  always_comb begin
    for (int r = 0; r < 8; r++) row_mask[r] = (3'(r) <= control_mid[28:26]);

    scan_now  = 64'd0;
    col_nz    = 8'h00;
    col_multi = 1'b0;
    single_v  = 8'h00;
    pos_col   = 3'd0;
    pos_row   = 3'd0;
    manual_v  = 8'h00;
    for (int w = 0; w < 4; w++) scan_words[w] = 32'd0;

    for (int c = 0; c < 8; c++) begin
      scan_v[c] = (3'(c) <= last_col) ? (col_eff[c] & row_mask) : 8'h00;
      // earlier columns end up in the higher bytes
      if (3'(c) <= last_col) scan_now = {scan_now[55:0], scan_v[c]};
      scan_words[c / 2][16 * (c % 2) +: 8] = scan_v[c];
      col_nz[c] = |scan_v[c];
      if ((scan_v[c] & (scan_v[c] - 8'd1)) != 8'h00) col_multi = 1'b1;
      single_v = single_v | scan_v[c];
      if (col_nz[c]) pos_col = 3'(c);
    end
    for (int r = 7; r >= 0; r--) begin
      if (single_v[r]) pos_row = 3'(r);
    end
    single_key = !col_multi && (col_nz != 8'h00) && ((col_nz & (col_nz - 8'd1)) == 8'h00);
    if (single_key) scan_set = kmsc_pkg::SCAN_SINGLE | {25'd0, pos_row, 1'b0, pos_col};
    else if (col_nz != 8'h00) scan_set = kmsc_pkg::SCAN_MULTI;
    else scan_set = 32'd0;

    for (int c = 0; c < 7; c++) begin
      if ((3'(c) < last_col) && control_mid[12 + c]) manual_v = manual_v | col_eff[c];
    end
    manual_v = manual_v & row_mask;
  end

  // ---------------------------------------------------------------- scan update
  always_comb begin
    control_nxt       = control_mid;
    manual_status_nxt = manual_mid;
    scan_status_nxt   = scan_status_r;
    previous_scan_nxt = previous_scan_r;
    for (int w = 0; w < 4; w++) multi_scan_nxt[w] = multi_scan_r[w];

    // with bit 21 set, the automatic scan runs only on the first press and the last release
    do_auto = run_scan ||
              (run_recalc && control_mid[12] && control_mid[29] &&
               !(control_mid[21] &&
                 (went_down ? (pressed_count_nxt != 7'd1) : (pressed_count_nxt != 7'd0))));
    do_manual = run_recalc && control_mid[12] && !control_mid[29];

    if (do_auto) begin
      for (int w = 0; w < 4; w++) multi_scan_nxt[w] = scan_words[w];
      scan_status_nxt   = (scan_status_r & ~kmsc_pkg::SCAN_CLEAR_MASK) | scan_set;
      previous_scan_nxt = scan_now;
      if (!run_scan && (scan_now != previous_scan_r))
        control_nxt = control_mid | kmsc_pkg::CTRL_MATRIX_INT;
    end
    if (do_manual) begin
      manual_status_nxt = {24'd0, manual_v};
      if (manual_v != 8'h00) control_nxt = control_mid | kmsc_pkg::CTRL_MATRIX_INT;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode_r  <= in_opcode;
      s1_offset_r  <= in_reg_offset;
      s1_bytes_r   <= in_access_bytes;
      s1_wdata_r   <= in_write_data;
      s1_row_r     <= in_matrix_row;
      s1_col_r     <= in_matrix_col;
      s1_didx_r    <= in_direct_index;
      s1_jidx_r    <= in_jog_index;
      s1_pressed_r <= in_pressed;
    end
    if (adv) begin
      out_read_data_r <= rd_v;
      out_access_ok_r <= ok_v;
      out_irq_r       <= kmsc_pkg::irq_level(control_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r        <= 32'd0;
      manual_status_r  <= 32'd0;
      scan_status_r    <= kmsc_pkg::SCAN_RESET;
      debounce_r       <= kmsc_pkg::DEBOUNCE_RESET;
      direct_changed_r <= 1'b0;
      previous_scan_r  <= 64'd0;
      direct_map_r     <= 8'h00;
      pressed_count_r  <= 7'd0;
      for (int w = 0; w < 4; w++) multi_scan_r[w] <= 32'd0;
      for (int j = 0; j < 2; j++) jog_state_r[j] <= 16'd0;
      for (int c = 0; c < MATRIX_COLS; c++) matrix_map_r[c] <= '0;
    end else if (adv) begin
      control_r        <= control_nxt;
      manual_status_r  <= manual_status_nxt;
      scan_status_r    <= scan_status_nxt;
      debounce_r       <= debounce_nxt;
      direct_changed_r <= direct_changed_nxt;
      previous_scan_r  <= previous_scan_nxt;
      direct_map_r     <= direct_map_nxt;
      pressed_count_r  <= pressed_count_nxt;
      for (int w = 0; w < 4; w++) multi_scan_r[w] <= multi_scan_nxt[w];
      for (int j = 0; j < 2; j++) jog_state_r[j] <= jog_state_nxt[j];
      for (int c = 0; c < MATRIX_COLS; c++) matrix_map_r[c] <= col_eff[c][MATRIX_ROWS-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_access_ok = out_access_ok_r;
  assign out_irq       = out_irq_r;

  // ---------------------------------------------------------------- checks
  `KMSC_ASSERT_NXT(a_irq_tracks_control, adv, out_irq_r == kmsc_pkg::irq_level(control_r), "irq level does not match control register")
  `KMSC_ASSERT_IMP(a_refused_reads_zero, out_valid_r && !out_access_ok_r, out_read_data_r == 32'd0, "refused access returned data")
  `KMSC_ASSERT_NXT(a_key_items_not_bus, adv && (s1_opcode_r != kmsc_pkg::OP_BUS_READ) && (s1_opcode_r != kmsc_pkg::OP_BUS_WRITE), !out_access_ok_r && (out_read_data_r == 32'd0), "non-bus item flagged as bus access")
  `KMSC_ASSERT_IMP(a_empty_stage_ready, !s1_valid_r, in_ready, "input stage empty but not ready")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the keypad matrix scan controller top level.
`timescale 1ns / 1ps

module testbench;

  localparam int          STALL_LIMIT    = 2000;
  localparam int          TAIL_CYCLES    = 8;
  localparam int          ITEMS_PER_HALF = 194;
  localparam logic [2:0]  OP_UNDEFINED   = 3'd7;
  // Sensor phase tables, two bits per entry, entry 0 in the low bits
  localparam logic [7:0]  JOG_PHASE_UP   = 8'h72;
  localparam logic [7:0]  JOG_PHASE_DOWN = 8'h2d;
  localparam logic [15:0] JOG_OVF_KEEP   = 16'h4300;
  localparam logic [15:0] JOG_OVF_SET    = 16'h8000;
  localparam logic [15:0] JOG_UNF_KEEP   = 16'h8300;
  localparam logic [15:0] JOG_UNF_SET    = 16'h40ff;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  offset;
    logic [2:0]  nbytes;
    logic [31:0] wdata;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [2:0]  didx;
    logic        jidx;
    logic        pressed;
  } key_item_t;

  typedef struct packed {
    logic [31:0] rd;
    logic        ok;
    logic        irq;
  } pad_response_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [6:0]  in_reg_offset;
  logic [2:0]  in_access_bytes;
  logic [31:0] in_write_data;
  logic [2:0]  in_matrix_row;
  logic [2:0]  in_matrix_col;
  logic [2:0]  in_direct_index;
  logic        in_jog_index;
  logic        in_pressed;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_data;
  logic        out_access_ok;
  logic        out_irq;

  keypad_matrix_scan_controller_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_reg_offset  (in_reg_offset),
    .in_access_bytes(in_access_bytes),
    .in_write_data  (in_write_data),
    .in_matrix_row  (in_matrix_row),
    .in_matrix_col  (in_matrix_col),
    .in_direct_index(in_direct_index),
    .in_jog_index   (in_jog_index),
    .in_pressed     (in_pressed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_access_ok  (out_access_ok),
    .out_irq        (out_irq)
  );

  always #5 clk = ~clk;

  key_item_t     pending_items[$];
  pad_response_t expected_responses[$];
  logic [63:0]   gen_keys;
  int send_idle_pct, recv_stall_pct;
  int items_launched, items_accepted, responses_seen, fail_count, stuck_cycles;
  int n_reads, n_writes, n_matrix, n_direct, n_jog, n_ignored, n_rejected, n_irq;

  // Shadow copy of the block state
  logic [31:0] kp_ctrl, kp_manual, kp_scan;
  logic [31:0] kp_multi [4];
  logic [15:0] kp_debounce;
  logic        kp_dchanged;
  logic [63:0] kp_prev_scan;
  logic [7:0]  kp_keys [8];
  logic [7:0]  kp_direct;
  logic [6:0]  kp_held;
  logic [15:0] kp_jog [2];

  task automatic clear_keypad_state();
    int i;
    kp_ctrl      = '0;
    kp_manual    = '0;
    kp_scan      = kmsc_pkg::SCAN_RESET;
    kp_debounce  = kmsc_pkg::DEBOUNCE_RESET;
    kp_dchanged  = 1'b0;
    kp_prev_scan = '0;
    kp_direct    = '0;
    kp_held      = '0;
    for (i = 0; i < 4; i++) kp_multi[i] = '0;
    for (i = 0; i < 8; i++) kp_keys[i] = '0;
    kp_jog[0] = '0;
    kp_jog[1] = '0;
  endtask

  function automatic logic interrupt_level(input logic [31:0] c);
    return ((c & kmsc_pkg::IRQ_MATRIX_MASK) == kmsc_pkg::IRQ_MATRIX_MASK) ||
           ((c & kmsc_pkg::IRQ_DIRECT_MASK) == kmsc_pkg::IRQ_DIRECT_MASK);
  endfunction

  function automatic logic [7:0] rows_in_use(input logic [31:0] c);
    logic [8:0] m;
    m = (9'd1 << (c[28:26] + 1)) - 9'd1;
    return m[7:0];
  endfunction

  function automatic logic [6:0] reg_addr(input logic [3:0] idx);
    return {idx, 3'b000};
  endfunction

  task automatic run_auto_scan(input logic raise);
    logic [63:0] snap;
    logic [7:0]  v, msk;
    int          c, r, keys, last;
    snap = '0;
    keys = 0;
    last = int'(kp_ctrl[25:23]);
    msk  = rows_in_use(kp_ctrl);
    for (c = 0; c < 4; c++) kp_multi[c] = '0;
    kp_scan = kp_scan & ~kmsc_pkg::SCAN_CLEAR_MASK;
    for (c = 0; c <= last; c++) begin
      v = kp_keys[c] & msk;
      snap = {snap[55:0], v};
      kp_multi[c / 2] = kp_multi[c / 2] | ({24'd0, v} << (16 * (c % 2)));
      if (v != 8'd0) begin
        if ((v & (v - 8'd1)) != 8'd0) begin
          keys += 2;
        end else begin
          // position is taken from the first lone key only
          if (keys == 0) begin
            r = 0;
            while (!v[r]) r++;
            kp_scan = kp_scan | c | (r << 4);
          end
          keys++;
        end
      end
    end
    if (keys == 1) kp_scan = kp_scan | kmsc_pkg::SCAN_SINGLE;
    else if (keys != 0) kp_scan = kp_scan | kmsc_pkg::SCAN_MULTI;
    if (raise && snap != kp_prev_scan) kp_ctrl = kp_ctrl | kmsc_pkg::CTRL_MATRIX_INT;
    kp_prev_scan = snap;
  endtask

  task automatic rescan_matrix(input logic went_down);
    logic [7:0] v;
    int         c, lim;
    if (kp_ctrl[12]) begin
      if (kp_ctrl[29]) begin
        // single-key mode scans only on the first press and the last release
        if (!(kp_ctrl[21] && ((went_down && kp_held != 7'd1) ||
                              (!went_down && kp_held != 7'd0))))
          run_auto_scan(1'b1);
      end else begin
        v = '0;
        lim = int'(kp_ctrl[25:23]);
        for (c = 0; c < lim; c++)
          if (kp_ctrl[12 + c]) v = v | kp_keys[c];
        v = v & rows_in_use(kp_ctrl);
        if (v != 8'd0) kp_ctrl = kp_ctrl | kmsc_pkg::CTRL_MATRIX_INT;
        kp_manual = {24'd0, v};
      end
    end
  endtask

  task automatic step_jog(input logic idx, input logic up);
    logic [15:0] s;
    logic [1:0]  ph;
    s = kp_jog[idx];
    if (up) begin
      if (s[7:0] == 8'hff) s = (s & JOG_OVF_KEEP) | JOG_OVF_SET;
      else s = s + 16'd1;
      ph = JOG_PHASE_UP[{s[13:12], 1'b0} +: 2];
    end else begin
      if (s[7:0] == 8'h00) s = (s & JOG_UNF_KEEP) | JOG_UNF_SET;
      else s = s - 16'd1;
      ph = JOG_PHASE_DOWN[{s[13:12], 1'b0} +: 2];
    end
    kp_jog[idx] = (s & kmsc_pkg::JOG_MASK) | {2'b00, ph, 12'h000};
    kp_ctrl = kp_ctrl | kmsc_pkg::CTRL_DIRECT_INT;
  endtask

  task automatic register_access(input key_item_t it, output logic [31:0] rd,
                                 output logic ok);
    logic [31:0] v;
    logic        wr;
    logic [3:0]  idx;
    v  = '0;
    rd = '0;
    ok = 1'b0;
    wr = (it.op == kmsc_pkg::OP_BUS_WRITE);
    idx = it.offset[6:3];
    if (it.nbytes == kmsc_pkg::BUS_BYTES && it.offset[2:0] == 3'd0 &&
        it.offset <= kmsc_pkg::LAST_OFFSET) begin
      ok = 1'b1;
      case (idx)
        kmsc_pkg::REG_CONTROL: begin
          if (wr) begin
            kp_ctrl = (kp_ctrl & kmsc_pkg::CTRL_KEEP_MASK) |
                      (it.wdata & kmsc_pkg::CTRL_WRITE_MASK);
            if (it.wdata[31]) run_auto_scan(1'b0);
            else rescan_matrix(1'b0);
          end else begin
            v = kp_ctrl;
            kp_ctrl = kp_ctrl & ~kmsc_pkg::CTRL_KEEP_MASK;
          end
        end
        kmsc_pkg::REG_DIRECT: begin
          if (!wr) begin
            v = {kp_dchanged, 23'd0, ~kp_direct};
            if (kp_ctrl[2]) v[1:0] = kp_jog[0][13:12];
            if (kp_ctrl[3]) v[3:2] = kp_jog[0][13:12];
            kp_dchanged = 1'b0;
          end
        end
        kmsc_pkg::REG_JOG: begin
          if (wr) begin
            kp_jog[0] = (kp_jog[0] & kmsc_pkg::JOG_KEEP_MASK) |
                        (it.wdata[15:0] & kmsc_pkg::JOG_MASK);
            kp_jog[1] = (kp_jog[1] & kmsc_pkg::JOG_KEEP_MASK) |
                        (it.wdata[31:16] & kmsc_pkg::JOG_MASK);
          end else begin
            v = {kp_jog[1] & kmsc_pkg::JOG_MASK, kp_jog[0] & kmsc_pkg::JOG_MASK};
            kp_jog[0] = kp_jog[0] & ~kmsc_pkg::JOG_FLAG_MASK;
            kp_jog[1] = kp_jog[1] & ~kmsc_pkg::JOG_FLAG_MASK;
          end
        end
        kmsc_pkg::REG_MANUAL: begin
          if (!wr) begin
            v = kp_manual;
            kp_manual = kp_manual & ~kmsc_pkg::STATUS_CHANGED;
          end
        end
        kmsc_pkg::REG_SCAN: if (!wr) v = kp_scan;
        kmsc_pkg::REG_MULTI0, kmsc_pkg::REG_MULTI1,
        kmsc_pkg::REG_MULTI2, kmsc_pkg::REG_MULTI3: begin
          if (!wr) v = kp_multi[2'(idx - kmsc_pkg::REG_MULTI0)];
        end
        default: begin
          if (wr) kp_debounce = it.wdata[15:0];
          else v = {16'd0, kp_debounce};
        end
      endcase
      rd = wr ? 32'd0 : v;
    end
  endtask

  task automatic keypad_response(input key_item_t it, output pad_response_t res);
    logic [31:0] rd;
    logic        ok;
    rd = '0;
    ok = 1'b0;
    case (it.op)
      kmsc_pkg::OP_BUS_READ, kmsc_pkg::OP_BUS_WRITE: register_access(it, rd, ok);
      kmsc_pkg::OP_MATRIX_KEY: begin
        if (kp_keys[it.col][it.row] != it.pressed) begin
          kp_keys[it.col][it.row] = it.pressed;
          kp_held = it.pressed ? kp_held + 7'd1 : kp_held - 7'd1;
          kp_manual = kp_manual | kmsc_pkg::STATUS_CHANGED;
          rescan_matrix(it.pressed);
        end
      end
      kmsc_pkg::OP_DIRECT_KEY: begin
        if (kp_direct[it.didx] != it.pressed) begin
          kp_direct[it.didx] = it.pressed;
          kp_dchanged = 1'b1;
          kp_ctrl = kp_ctrl | kmsc_pkg::CTRL_DIRECT_INT;
        end
      end
      kmsc_pkg::OP_JOG_STEP: step_jog(it.jidx, it.pressed);
      default: ;
    endcase
    res.rd  = rd;
    res.ok  = ok;
    res.irq = interrupt_level(kp_ctrl);
  endtask

  task automatic queue_item(input key_item_t it);
    if (it.op == kmsc_pkg::OP_MATRIX_KEY) gen_keys[{it.col, it.row}] = it.pressed;
    pending_items.push_back(it);
  endtask

  task automatic queue_bus(input logic [2:0] op, input logic [6:0] offset,
                           input logic [2:0] nbytes, input logic [31:0] data);
    key_item_t it;
    it = '0;
    it.op = op;
    it.offset = offset;
    it.nbytes = nbytes;
    it.wdata = data;
    queue_item(it);
  endtask

  // sel picks the matrix row, the direct key or the dial
  task automatic queue_event(input logic [2:0] op, input logic [2:0] sel,
                             input logic [2:0] col, input logic pressed);
    key_item_t it;
    it = '0;
    it.op = op;
    it.row = sel;
    it.col = col;
    it.didx = sel;
    it.jidx = sel[0];
    it.pressed = pressed;
    queue_item(it);
  endtask

  function automatic logic [7:0] jog_count_pick();
    case ($urandom_range(4))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hfe;
      3: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_random_item();
    key_item_t it;
    int        pick, held, idx;
    pick = $urandom_range(99);
    it.offset = 7'($urandom_range(127));
    it.nbytes = 3'($urandom_range(4, 1));
    it.wdata = $urandom;
    it.row = 3'($urandom_range(7));
    it.col = 3'($urandom_range(7));
    it.didx = 3'($urandom_range(7));
    it.jidx = 1'($urandom_range(1));
    it.pressed = 1'($urandom_range(1));
    if (pick < 30) it.op = kmsc_pkg::OP_BUS_READ;
    else if (pick < 50) it.op = kmsc_pkg::OP_BUS_WRITE;
    else if (pick < 75) it.op = kmsc_pkg::OP_MATRIX_KEY;
    else if (pick < 87) it.op = kmsc_pkg::OP_DIRECT_KEY;
    else if (pick < 97) it.op = kmsc_pkg::OP_JOG_STEP;
    else it.op = 3'($urandom_range(7, 5));
    if (it.op == kmsc_pkg::OP_BUS_READ || it.op == kmsc_pkg::OP_BUS_WRITE) begin
      // mostly well-formed accesses to mapped registers
      if ($urandom_range(9) != 0) begin
        it.offset = reg_addr(4'($urandom_range(9)));
        it.nbytes = kmsc_pkg::BUS_BYTES;
      end
      if (it.offset == reg_addr(kmsc_pkg::REG_CONTROL) && $urandom_range(9) < 7)
        it.wdata[12] = 1'b1;
      if (it.offset == reg_addr(kmsc_pkg::REG_JOG)) begin
        it.wdata[7:0] = jog_count_pick();
        it.wdata[23:16] = jog_count_pick();
      end
    end
    if (it.op == kmsc_pkg::OP_MATRIX_KEY && $urandom_range(4) != 0) begin
      // keep few keys down so single-key scans stay reachable
      held = $countones(gen_keys);
      it.pressed = (held == 0) || (held < 3 && $urandom_range(1) == 1);
      do idx = $urandom_range(63); while (gen_keys[idx[5:0]] == it.pressed);
      it.col = idx[5:3];
      it.row = idx[2:0];
    end
    queue_item(it);
  endtask

  task automatic wait_for_drain();
    while (pending_items.size() != 0 || items_launched != items_accepted ||
           expected_responses.size() != 0)
      @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    fail_count++;
  endtask

  // Driver: hold the item until it is taken, then advance or go idle
  always @(negedge clk) begin : drive_items
    key_item_t nxt;
    if (!in_valid || items_accepted == items_launched) begin
      if (rst_n && pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_opcode       <= nxt.op;
        in_reg_offset   <= nxt.offset;
        in_access_bytes <= nxt.nbytes;
        in_write_data   <= nxt.wdata;
        in_matrix_row   <= nxt.row;
        in_matrix_col   <= nxt.col;
        in_direct_index <= nxt.didx;
        in_jog_index    <= nxt.jidx;
        in_pressed      <= nxt.pressed;
        in_valid        <= 1'b1;
        items_launched++;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: check responses, predict accepted items, watch for a hang
  always @(posedge clk) begin : watch_ports
    key_item_t     it;
    pad_response_t want;
    logic          progress;
    if (rst_n) begin
      progress = 1'b0;
      if (out_valid && out_ready) begin
        progress = 1'b1;
        responses_seen++;
        if (out_irq) n_irq++;
        if (expected_responses.size() == 0) begin
          $display("%0t: response with none expected, read_data %h access_ok %b irq %b",
                   $time, out_read_data, out_access_ok, out_irq);
          fail_count++;
        end else begin
          want = expected_responses.pop_front();
          if (out_read_data !== want.rd) report_mismatch("read_data", want.rd, out_read_data);
          if (out_access_ok !== want.ok)
            report_mismatch("access_ok", {31'd0, want.ok}, {31'd0, out_access_ok});
          if (out_irq !== want.irq) report_mismatch("irq", {31'd0, want.irq}, {31'd0, out_irq});
        end
      end
      if (in_valid && in_ready) begin
        progress = 1'b1;
        it.op      = in_opcode;
        it.offset  = in_reg_offset;
        it.nbytes  = in_access_bytes;
        it.wdata   = in_write_data;
        it.row     = in_matrix_row;
        it.col     = in_matrix_col;
        it.didx    = in_direct_index;
        it.jidx    = in_jog_index;
        it.pressed = in_pressed;
        keypad_response(it, want);
        expected_responses.push_back(want);
        items_accepted++;
        case (it.op)
          kmsc_pkg::OP_BUS_READ:   n_reads++;
          kmsc_pkg::OP_BUS_WRITE:  n_writes++;
          kmsc_pkg::OP_MATRIX_KEY: n_matrix++;
          kmsc_pkg::OP_DIRECT_KEY: n_direct++;
          kmsc_pkg::OP_JOG_STEP:   n_jog++;
          default:                 n_ignored++;
        endcase
        if ((it.op == kmsc_pkg::OP_BUS_READ || it.op == kmsc_pkg::OP_BUS_WRITE) && !want.ok)
          n_rejected++;
      end
      stuck_cycles = progress ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : run_test
    int phase, half;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_opcode = '0;
    in_reg_offset = '0;
    in_access_bytes = '0;
    in_write_data = '0;
    in_matrix_row = '0;
    in_matrix_col = '0;
    in_direct_index = '0;
    in_jog_index = 1'b0;
    in_pressed = 1'b0;
    gen_keys = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clear_keypad_state();

    // Reset values, rejected accesses and the unknown opcode
    queue_bus(kmsc_pkg::OP_BUS_READ, reg_addr(kmsc_pkg::REG_CONTROL), kmsc_pkg::BUS_BYTES, 32'd0);
    queue_bus(kmsc_pkg::OP_BUS_READ, reg_addr(kmsc_pkg::REG_SCAN), kmsc_pkg::BUS_BYTES, 32'd0);
    queue_bus(kmsc_pkg::OP_BUS_READ, reg_addr(kmsc_pkg::REG_CONTROL), 3'd1, 32'd0);
    queue_bus(kmsc_pkg::OP_BUS_READ, 7'h04, kmsc_pkg::BUS_BYTES, 32'd0);
    queue_bus(kmsc_pkg::OP_BUS_WRITE, 7'h50, kmsc_pkg::BUS_BYTES, 32'hffff_ffff);
    queue_bus(kmsc_pkg::OP_BUS_READ, 7'h7f, kmsc_pkg::BUS_BYTES, 32'd0);
    queue_bus(kmsc_pkg::OP_BUS_WRITE, reg_addr(kmsc_pkg::REG_SCAN), kmsc_pkg::BUS_BYTES,
              32'hffff_ffff);
    queue_event(OP_UNDEFINED, 3'd7, 3'd7, 1'b1);
    // Manual scan over columns 0 and 1, all rows in use
    queue_bus(kmsc_pkg::OP_BUS_WRITE, reg_addr(kmsc_pkg::REG_CONTROL), kmsc_pkg::BUS_BYTES,
              32'h1f80_3800);
    queue_event(kmsc_pkg::OP_MATRIX_KEY, 3'd7, 3'd0, 1'b1);
    queue_event(kmsc_pkg::OP_MATRIX_KEY, 3'd7, 3'd0, 1'b1);
    queue_bus(kmsc_pkg::OP_BUS_READ, reg_addr(kmsc_pkg::REG_MANUAL), kmsc_pkg::BUS_BYTES, 32'd0);
    queue_bus(kmsc_pkg::OP_BUS_READ, reg_addr(kmsc_pkg::REG_CONTROL), kmsc_pkg::BUS_BYTES, 32'd0);
    // Automatic scan: a lone key then two keys in the last column
    queue_bus(kmsc_pkg::OP_BUS_WRITE, reg_addr(kmsc_pkg::REG_CONTROL), kmsc_pkg::BUS_BYTES,
              32'hbf80_1800);
    queue_event(kmsc_pkg::OP_MATRIX_KEY, 3'd0, 3'd7, 1'b1);
    queue_event(kmsc_pkg::OP_MATRIX_KEY, 3'd3, 3'd7, 1'b1);
    queue_bus(kmsc_pkg::OP_BUS_READ, reg_addr(kmsc_pkg::REG_SCAN), kmsc_pkg::BUS_BYTES, 32'd0);
    queue_bus(kmsc_pkg::OP_BUS_READ, reg_addr(kmsc_pkg::REG_MULTI3), kmsc_pkg::BUS_BYTES, 32'd0);
    queue_event(kmsc_pkg::OP_MATRIX_KEY, 3'd1, 3'd1, 1'b0);
    // A direct key, jog overflow and underflow, phase shown in the direct register
    queue_event(kmsc_pkg::OP_DIRECT_KEY, 3'd7, 3'd0, 1'b1);
    queue_bus(kmsc_pkg::OP_BUS_WRITE, reg_addr(kmsc_pkg::REG_CONTROL), kmsc_pkg::BUS_BYTES,
              32'h0000_000f);
    queue_bus(kmsc_pkg::OP_BUS_WRITE, reg_addr(kmsc_pkg::REG_JOG), kmsc_pkg::BUS_BYTES,
              32'h00ff_0000);
    queue_event(kmsc_pkg::OP_JOG_STEP, 3'd1, 3'd0, 1'b1);
    queue_event(kmsc_pkg::OP_JOG_STEP, 3'd0, 3'd0, 1'b0);
    queue_bus(kmsc_pkg::OP_BUS_READ, reg_addr(kmsc_pkg::REG_DIRECT), kmsc_pkg::BUS_BYTES, 32'd0);
    queue_bus(kmsc_pkg::OP_BUS_READ, reg_addr(kmsc_pkg::REG_JOG), kmsc_pkg::BUS_BYTES, 32'd0);
    queue_bus(kmsc_pkg::OP_BUS_WRITE, reg_addr(kmsc_pkg::REG_DEBOUNCE), kmsc_pkg::BUS_BYTES,
              32'hffff_ffff);
    queue_bus(kmsc_pkg::OP_BUS_READ, reg_addr(kmsc_pkg::REG_DEBOUNCE), kmsc_pkg::BUS_BYTES,
              32'd0);

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait_for_drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      // hold the sender halfway until every response is back
      for (half = 0; half < 2; half++) begin
        repeat (ITEMS_PER_HALF) queue_random_item();
        wait_for_drain();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_responses.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, expected_responses.size());
      fail_count++;
    end
    $display("Ran %0d items: %0d reads, %0d writes (%0d rejected), %0d matrix, %0d direct, %s",
             items_accepted, n_reads, n_writes, n_rejected, n_matrix, n_direct,
             $sformatf("%0d jog, %0d undefined", n_jog, n_ignored));
    $display("Checked %0d responses (%0d with irq high) under four pacing modes, %0d errors",
             responses_seen, n_irq, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
